// ===== design/spt_pkg.sv =====
package spt_pkg;

    localparam int TRAJECTORIES = 16;
    localparam int MAX_PEAKS    = 32;
    localparam int SLOT_W       = (TRAJECTORIES > 1) ? $clog2(TRAJECTORIES) : 1;
    localparam int PEAK_W       = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
    localparam int CNT_W        = $clog2(MAX_PEAKS + 1);
    localparam int POS_W        = 16;
    localparam int MAG_W        = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int IDX_OUT_W    = 4;

    localparam logic signed [MAG_W-1:0] SILENT_DB = -16'sd1920;
    localparam logic signed [MAG_W:0]   ONE_DB    = 17'sd16;
    localparam logic signed [MAG_W:0]   MAG_MIN   = -17'sd32768;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BIN_CHANGE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENT_FRAMES  = 1'd1;

    typedef struct packed {
        logic              load;
        logic              clr_best;
        logic              scan_en;
        logic              decide;
        logic              fill;
        logic              out_en;
        logic              out_last;
        logic              frame_done;
        logic [PEAK_W-1:0] peak;
        logic [SLOT_W-1:0] slot;
    } t_cmd;

    typedef struct packed {
        logic             slot_active;
        logic [CNT_W-1:0] peak_count;
    } t_status;

endpackage

// ===== design/spectral_peak_tracker.sv =====
// Throughput: a peak beat is taken every cycle while the frame is loading.
// A frame-end beat keeps the block busy (o_busy high) while it scans every stored peak
// for each active slot, decides each slot, fills free slots and sends the results.
// The first result follows once the scan, decision and fill phases are done.
// Reset (i_rst_n low, synchronous) frees every slot, empties the frame and restores the registers.
// The receiver cannot stall: each result is held for exactly one cycle.
module spectral_peak_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [spt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [spt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Input beats.
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_peak_present,
    input  logic [spt_pkg::POS_W-1:0]         i_peak_position,
    input  logic signed [spt_pkg::MAG_W-1:0]  i_peak_magnitude,
    input  logic                              i_frame_last,
    // Result beats.
    output logic                              o_result_valid,
    output logic [spt_pkg::IDX_OUT_W-1:0]     o_traj_index,
    output logic                              o_position_valid,
    output logic [spt_pkg::POS_W-1:0]         o_traj_position,
    output logic signed [spt_pkg::MAG_W-1:0]  o_traj_magnitude,
    output logic                              o_result_last
);

    // The controller sequences the phases of a frame: loading, the per-slot
    // nearest-peak scan, the decision for each slot, the filling of free slots
    // with unclaimed peaks, and finally one result beat per slot.
    spt_pkg::t_cmd    w_cmd;
    spt_pkg::t_status w_status;

    spt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_frame_last (i_frame_last),
        .i_status     (w_status),
        .o_cmd        (w_cmd),
        .o_busy       (o_busy)
    );

    // The datapath holds the slots, the frame's peaks and the compare unit.
    spt_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_peak_present   (i_peak_present),
        .i_peak_position  (i_peak_position),
        .i_peak_magnitude (i_peak_magnitude),
        .o_result_valid   (o_result_valid),
        .o_traj_index     (o_traj_index),
        .o_position_valid (o_position_valid),
        .o_traj_position  (o_traj_position),
        .o_traj_magnitude (o_traj_magnitude),
        .o_result_last    (o_result_last)
    );

endmodule

// ===== design/spt_ctrl.sv =====
module spt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_frame_last,
    input  spt_pkg::t_status i_status,
    output spt_pkg::t_cmd   o_cmd,
    output logic            o_busy
);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_FILL, S_OUT} t_state;

    t_state                      r_state, n_state;
    logic [spt_pkg::SLOT_W-1:0]  r_slot, n_slot;
    logic [spt_pkg::CNT_W-1:0]   r_peak, n_peak;
    logic                        w_last_slot;
    logic                        w_peaks_done;

    assign w_last_slot  = (r_slot == spt_pkg::SLOT_W'(spt_pkg::TRAJECTORIES - 1));
    assign w_peaks_done = (r_peak >= i_status.peak_count);
    assign o_busy       = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        n_peak  = r_peak;
        o_cmd   = '0;
        o_cmd.peak = r_peak[spt_pkg::PEAK_W-1:0];
        o_cmd.slot = r_slot;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_frame_last) begin
                        o_cmd.clr_best = 1'b1;
                        n_slot  = '0;
                        n_peak  = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (!i_status.slot_active || w_peaks_done) begin
                    n_state = S_DECIDE;
                end else begin
                    o_cmd.scan_en = 1'b1;
                    n_peak = r_peak + 1'b1;
                end
            end
            S_DECIDE: begin
                o_cmd.decide   = 1'b1;
                o_cmd.clr_best = 1'b1;
                n_peak = '0;
                if (w_last_slot) begin
                    n_state = S_FILL;
                end else begin
                    n_slot  = r_slot + 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_FILL: begin
                if (w_peaks_done) begin
                    n_slot  = '0;
                    n_state = S_OUT;
                end else begin
                    o_cmd.fill = 1'b1;
                    n_peak = r_peak + 1'b1;
                end
            end
            S_OUT: begin
                o_cmd.out_en = 1'b1;
                if (w_last_slot) begin
                    o_cmd.out_last   = 1'b1;
                    o_cmd.frame_done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= '0;
            r_peak  <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_peak  <= n_peak;
        end
    end

`ifndef SYNTH
    a_out_exits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> (r_state == S_OUT || r_state == S_IDLE))
        else $error("output phase left to a wrong state");
    a_last_is_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_last |-> (o_cmd.out_en && w_last_slot))
        else $error("last result flagged off the final slot");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan_en |-> (r_peak < i_status.peak_count))
        else $error("scan past the stored peaks");
`endif

endmodule

// ===== design/spt_datapath.sv =====
module spt_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  spt_pkg::t_cmd                         i_cmd,
    output spt_pkg::t_status                      o_status,
    input  logic                                  i_cfg_we,
    input  logic [spt_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [spt_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_peak_present,
    input  logic [spt_pkg::POS_W-1:0]             i_peak_position,
    input  logic signed [spt_pkg::MAG_W-1:0]      i_peak_magnitude,
    output logic                                  o_result_valid,
    output logic [spt_pkg::IDX_OUT_W-1:0]         o_traj_index,
    output logic                                  o_position_valid,
    output logic [spt_pkg::POS_W-1:0]             o_traj_position,
    output logic signed [spt_pkg::MAG_W-1:0]      o_traj_magnitude,
    output logic                                  o_result_last
);

    localparam int T = spt_pkg::TRAJECTORIES;
    localparam int P = spt_pkg::MAX_PEAKS;

    logic [15:0]                          r_max_bin;
    logic [7:0]                           r_silent;
    logic [T-1:0]                         r_active;
    logic [T-1:0]                         r_fresh;
    logic [spt_pkg::POS_W-1:0]            r_slot_pos [T];
    logic signed [spt_pkg::MAG_W-1:0]     r_slot_mag [T];
    logic [spt_pkg::POS_W-1:0]            r_peak_pos [P];
    logic signed [spt_pkg::MAG_W-1:0]     r_peak_mag [P];
    logic [P-1:0]                         r_taken;
    logic [spt_pkg::CNT_W-1:0]            r_count;
    logic                                 r_found;
    logic [spt_pkg::PEAK_W-1:0]           r_best;
    logic [spt_pkg::POS_W-1:0]            r_bestd;

    logic [spt_pkg::POS_W-1:0]            w_ppos;
    logic [spt_pkg::POS_W-1:0]            w_spos;
    logic [spt_pkg::POS_W-1:0]            w_dist;
    logic signed [spt_pkg::MAG_W:0]       w_limit;
    logic signed [spt_pkg::MAG_W:0]       w_smag;
    logic signed [spt_pkg::MAG_W:0]       w_dec;
    logic                                 w_any_free;
    logic [spt_pkg::SLOT_W-1:0]           w_free;

    assign o_status.slot_active = r_active[i_cmd.slot];
    assign o_status.peak_count  = r_count;

    assign w_ppos  = r_peak_pos[i_cmd.peak];
    assign w_spos  = r_slot_pos[i_cmd.slot];
    assign w_dist  = (w_ppos > w_spos) ? (w_ppos - w_spos) : (w_spos - w_ppos);
    assign w_limit = 17'(spt_pkg::SILENT_DB) - (spt_pkg::ONE_DB * $signed({9'd0, r_silent}));
    assign w_smag  = 17'(r_slot_mag[i_cmd.slot]);
    assign w_dec   = w_smag - spt_pkg::ONE_DB;

    // Lowest free slot for a new trajectory.
    always_comb begin
        w_any_free = 1'b0;
        w_free     = '0;
        for (int k = T - 1; k >= 0; k--) begin
            if (!r_active[k]) begin
                w_any_free = 1'b1;
                w_free     = spt_pkg::SLOT_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bin <= 16'd48;
            r_silent  <= 8'd3;
            r_active  <= '0;
            r_taken   <= '0;
            r_count   <= '0;
            r_found   <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_cmd.out_en;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    spt_pkg::CFG_MAX_BIN_CHANGE: r_max_bin <= i_cfg_data;
                    spt_pkg::CFG_SILENT_FRAMES:  r_silent  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.load && i_peak_present &&
                r_count < spt_pkg::CNT_W'(P)) begin
                r_count <= r_count + 1'b1;
                r_taken[r_count[spt_pkg::PEAK_W-1:0]] <= 1'b0;
            end
            if (i_cmd.clr_best) begin
                r_found <= 1'b0;
            end
            if (i_cmd.scan_en && !r_taken[i_cmd.peak]) begin
                if (!r_found || w_dist < r_bestd) begin
                    r_found <= 1'b1;
                    r_best  <= i_cmd.peak;
                    r_bestd <= w_dist;
                end
            end
            if (i_cmd.decide && r_active[i_cmd.slot]) begin
                if (r_found && r_bestd <= r_max_bin) begin
                    r_fresh[i_cmd.slot] <= 1'b1;
                    r_taken[r_best]     <= 1'b1;
                end else begin
                    r_fresh[i_cmd.slot] <= 1'b0;
                    if (w_smag <= w_limit) begin
                        r_active[i_cmd.slot] <= 1'b0;
                    end
                end
            end
            if (i_cmd.fill && !r_taken[i_cmd.peak] && w_any_free) begin
                r_active[w_free] <= 1'b1;
                r_fresh[w_free]  <= 1'b1;
            end
            if (i_cmd.frame_done) begin
                r_count <= '0;
                r_taken <= '0;
            end
        end
    end

    // Payload stores, no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_peak_present && r_count < spt_pkg::CNT_W'(P)) begin
            r_peak_pos[r_count[spt_pkg::PEAK_W-1:0]] <= i_peak_position;
            r_peak_mag[r_count[spt_pkg::PEAK_W-1:0]] <= i_peak_magnitude;
        end
        if (i_cmd.decide && r_active[i_cmd.slot]) begin
            if (r_found && r_bestd <= r_max_bin) begin
                r_slot_pos[i_cmd.slot] <= r_peak_pos[r_best];
                r_slot_mag[i_cmd.slot] <= r_peak_mag[r_best];
            end else if (w_smag <= w_limit) begin
                r_slot_mag[i_cmd.slot] <= r_slot_mag[i_cmd.slot];
            end else if (w_smag <= 17'(spt_pkg::SILENT_DB)) begin
                r_slot_mag[i_cmd.slot] <= (w_dec < spt_pkg::MAG_MIN) ?
                    spt_pkg::MAG_MIN[spt_pkg::MAG_W-1:0] : w_dec[spt_pkg::MAG_W-1:0];
            end else begin
                r_slot_mag[i_cmd.slot] <= spt_pkg::SILENT_DB;
            end
        end
        if (i_cmd.fill && !r_taken[i_cmd.peak] && w_any_free) begin
            r_slot_pos[w_free] <= w_ppos;
            r_slot_mag[w_free] <= r_peak_mag[i_cmd.peak];
        end
        if (i_cmd.out_en) begin
            o_traj_index     <= spt_pkg::IDX_OUT_W'(i_cmd.slot);
            o_position_valid <= r_active[i_cmd.slot];
            o_traj_position  <= r_active[i_cmd.slot] ? w_spos : '0;
            o_traj_magnitude <= (r_active[i_cmd.slot] && r_fresh[i_cmd.slot]) ?
                                r_slot_mag[i_cmd.slot] : spt_pkg::SILENT_DB;
            o_result_last    <= i_cmd.out_last;
        end
    end

endmodule
